/* src/rtpamr_pkg.sv */
// ----------------------------------------------------------------------------
// rtpamr_pkg: shared types and constants of the RTP AMR depacketizer
// Status codes, header positions, the item moved from the front end to the
// back end, and the frame-type tables of the bandwidth-efficient payload.
// ----------------------------------------------------------------------------
package rtpamr_pkg;

	localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
	localparam logic [15:0] SEQ_WINDOW       = 16'd1000;
	localparam logic [7:0]  NO_DATA_BYTE     = 8'h7C;
	localparam int unsigned NB_STEP          = 160;
	localparam int unsigned WB_STEP          = 320;
	localparam logic [31:0] NB_SAT_LIMIT     = 32'(65536 * NB_STEP);
	localparam logic [31:0] WB_SAT_LIMIT     = 32'(65536 * WB_STEP);
	localparam logic [15:0] REPEAT_MAX       = 16'hFFFF;

	// x / 5 == (x * DIV5_MULT) >> DIV5_SHIFT for every x below 2**22
	localparam logic [19:0] DIV5_MULT        = 20'd838861;
	localparam int unsigned DIV5_SHIFT       = 22;

	localparam logic [7:0]  POS_VERSION      = 8'd0;
	localparam logic [7:0]  POS_SEQ_HI       = 8'd2;
	localparam logic [7:0]  POS_SEQ_LO       = 8'd3;
	localparam logic [7:0]  POS_TS_HI        = 8'd4;
	localparam logic [7:0]  POS_TS_LO        = 8'd7;
	localparam logic [7:0]  POS_SSRC_HI      = 8'd8;
	localparam logic [7:0]  HDR_LEN          = 8'd12;
	localparam logic [7:0]  POS_HDR_END      = HDR_LEN - 8'd1;
	localparam logic [7:0]  POS_CMR          = HDR_LEN;
	localparam logic [7:0]  POS_TOC          = HDR_LEN + 8'd1;
	localparam logic [7:0]  POS_MAX          = 8'hFF;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [2:0] {
		ST_OK             = 3'd0,
		ST_BAD_VERSION    = 3'd1,
		ST_DUPLICATE      = 3'd2,
		ST_TOO_SHORT      = 3'd3,
		ST_BAD_FRAME_TYPE = 3'd4,
		ST_TRUNCATED      = 3'd5
	} status_t;

	typedef enum logic {
		KIND_DATA,
		KIND_GAP
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic        has_byte;
		logic [7:0]  data;
		status_t     status;
		logic        done;
		logic [31:0] timestamp;
		logic [31:0] prev_timestamp;
	} item_t;

	function automatic logic ft_valid(input logic wide, input logic [3:0] ft);
		ft_valid = wide ? (ft <= 4'd9) : (ft <= 4'd8);
	endfunction

	// ceil(speech bits / 8) for each frame type
	function automatic logic [5:0] speech_bytes(input logic wide, input logic [3:0] ft);
		logic [5:0] n;
		n = 6'd0;
		if (wide) begin
			case (ft)
				4'd0:    n = 6'd17;
				4'd1:    n = 6'd23;
				4'd2:    n = 6'd32;
				4'd3:    n = 6'd36;
				4'd4:    n = 6'd40;
				4'd5:    n = 6'd46;
				4'd6:    n = 6'd50;
				4'd7:    n = 6'd58;
				4'd8:    n = 6'd60;
				4'd9:    n = 6'd5;
				default: n = 6'd0;
			endcase
		end else begin
			case (ft)
				4'd0:    n = 6'd12;
				4'd1:    n = 6'd13;
				4'd2:    n = 6'd15;
				4'd3:    n = 6'd17;
				4'd4:    n = 6'd19;
				4'd5:    n = 6'd20;
				4'd6:    n = 6'd26;
				4'd7:    n = 6'd31;
				4'd8:    n = 6'd5;
				default: n = 6'd0;
			endcase
		end
		speech_bytes = n;
	endfunction

endpackage

/* src/rtpamr_in_if.sv */
// ----------------------------------------------------------------------------
// rtpamr_in_if: packet byte channel
// Valid/ready channel carrying one RTP packet byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface rtpamr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* src/rtpamr_out_if.sv */
// ----------------------------------------------------------------------------
// rtpamr_out_if: storage byte channel
// Valid/ready channel carrying one storage byte, its repeat count and status.
// ----------------------------------------------------------------------------
interface rtpamr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [15:0] repeat_count;
	logic [2:0]  status;
	logic        frame_done;

	modport source (output valid, output out_byte, output repeat_count, output status,
		output frame_done, input ready);
	modport sink   (input valid, input out_byte, input repeat_count, input status,
		input frame_done, output ready);
endinterface

/* src/rtpamr_front.sv */
// ----------------------------------------------------------------------------
// rtpamr_front: header parser and payload realigner
// Tracks the byte position, checks version, sequence and frame type, and
// pushes one classified item per byte that yields a result.
// ----------------------------------------------------------------------------
module rtpamr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wideband_mode,
	rtpamr_in_if.sink           packet,
	input  logic                queue_full,
	output logic                push,
	output rtpamr_pkg::item_t   push_item
);
	import rtpamr_pkg::*;

	logic [7:0]  pos_q, pos_d;
	logic        dropped_q, dropped_d;
	logic [15:0] seq_q, seq_d;
	logic [31:0] ts_q, ts_d;
	logic [31:0] ssrc_q, ssrc_d;
	logic [15:0] prev_seq_q, prev_seq_d;
	logic [31:0] prev_ts_q, prev_ts_d;
	logic [31:0] prev_ssrc_q, prev_ssrc_d;
	logic [7:0]  carry_q, carry_d;
	logic [5:0]  left_q, left_d;
	logic        take;
	logic        same_src;
	logic        dup;
	logic [3:0]  ft;
	logic [7:0]  b;
	logic        last;

	assign packet.ready = !queue_full;
	assign take         = packet.valid && !queue_full;
	assign b            = packet.data_byte;
	assign last         = packet.last_byte;
	assign ft           = {carry_q[2:0], b[7]};

	always_comb begin
		pos_d       = pos_q;
		dropped_d   = dropped_q;
		seq_d       = seq_q;
		ts_d        = ts_q;
		ssrc_d      = ssrc_q;
		prev_seq_d  = prev_seq_q;
		prev_ts_d   = prev_ts_q;
		prev_ssrc_d = prev_ssrc_q;
		carry_d     = carry_q;
		left_d      = left_q;
		same_src    = 1'b0;
		dup         = 1'b0;
		push        = 1'b0;
		push_item.kind           = KIND_DATA;
		push_item.has_byte       = 1'b0;
		push_item.data           = 8'h00;
		push_item.status         = ST_OK;
		push_item.done           = 1'b0;
		push_item.timestamp      = ts_q;
		push_item.prev_timestamp = prev_ts_q;
		if (take) begin
			if (!dropped_q) begin
				if (pos_q < HDR_LEN) begin
					if (pos_q == POS_SEQ_HI || pos_q == POS_SEQ_LO) begin
						seq_d = {seq_q[7:0], b};
					end else if (pos_q >= POS_TS_HI && pos_q <= POS_TS_LO) begin
						ts_d = {ts_q[23:0], b};
					end else if (pos_q >= POS_SSRC_HI) begin
						ssrc_d = {ssrc_q[23:0], b};
					end
					if (last) begin
						push             = 1'b1;
						push_item.status = ST_TOO_SHORT;
						dropped_d        = 1'b1;
					end else if (pos_q == POS_VERSION && b != RTP_VERSION_BYTE) begin
						push             = 1'b1;
						push_item.status = ST_BAD_VERSION;
						dropped_d        = 1'b1;
					end else if (pos_q == POS_HDR_END) begin
						same_src = (ssrc_d == prev_ssrc_q);
						dup = same_src && (seq_q <= prev_seq_q)
							&& ((prev_seq_q - seq_q) < SEQ_WINDOW);
						if (dup) begin
							push             = 1'b1;
							push_item.status = ST_DUPLICATE;
							dropped_d        = 1'b1;
						end else begin
							prev_seq_d  = seq_q;
							prev_ts_d   = ts_q;
							prev_ssrc_d = ssrc_d;
							if (same_src) begin
								push           = 1'b1;
								push_item.kind = KIND_GAP;
							end
						end
					end
				end else if (pos_q == POS_CMR) begin
					carry_d = b;
					if (b[3]) begin
						push             = 1'b1;
						push_item.status = ST_BAD_FRAME_TYPE;
						dropped_d        = 1'b1;
					end else if (last) begin
						push             = 1'b1;
						push_item.status = ST_TRUNCATED;
					end
				end else if (pos_q == POS_TOC) begin
					if (!ft_valid(wideband_mode, ft)) begin
						push             = 1'b1;
						push_item.status = ST_BAD_FRAME_TYPE;
						dropped_d        = 1'b1;
					end else begin
						left_d             = speech_bytes(wideband_mode, ft);
						carry_d            = b;
						push               = 1'b1;
						push_item.has_byte = 1'b1;
						push_item.data     = {1'b0, ft, 3'b100};
						push_item.status   = last ? ST_TRUNCATED : ST_OK;
					end
				end else if (left_q != 6'd0) begin
					carry_d            = b;
					left_d             = left_q - 6'd1;
					push               = 1'b1;
					push_item.has_byte = 1'b1;
					push_item.data     = {carry_q[5:0], b[7:6]};
					push_item.status   = (last && left_q != 6'd1) ? ST_TRUNCATED : ST_OK;
					push_item.done     = (left_q == 6'd1);
				end
			end
			if (last) begin
				pos_d     = 8'd0;
				dropped_d = 1'b0;
				left_d    = 6'd0;
			end else if (pos_q != POS_MAX) begin
				pos_d = pos_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 8'd0;
			dropped_q   <= 1'b0;
			seq_q       <= 16'd0;
			ts_q        <= 32'd0;
			ssrc_q      <= 32'd0;
			prev_seq_q  <= 16'd0;
			prev_ts_q   <= 32'd0;
			prev_ssrc_q <= 32'd0;
			carry_q     <= 8'd0;
			left_q      <= 6'd0;
		end else begin
			pos_q       <= pos_d;
			dropped_q   <= dropped_d;
			seq_q       <= seq_d;
			ts_q        <= ts_d;
			ssrc_q      <= ssrc_d;
			prev_seq_q  <= prev_seq_d;
			prev_ts_q   <= prev_ts_d;
			prev_ssrc_q <= prev_ssrc_d;
			carry_q     <= carry_d;
			left_q      <= left_d;
		end
	end

endmodule

/* src/rtpamr_queue.sv */
// ----------------------------------------------------------------------------
// rtpamr_queue: item queue between front end and back end
// Small first-in first-out store of classified items with full/empty flags.
// ----------------------------------------------------------------------------
module rtpamr_queue #(
	parameter int unsigned DEPTH = rtpamr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rtpamr_pkg::item_t   push_item,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output rtpamr_pkg::item_t   head
);
	import rtpamr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             mem [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/rtpamr_back.sv */
// ----------------------------------------------------------------------------
// rtpamr_back: result builder
// Turns queued items into results; for a timestamp gap it checks the step,
// divides the gap by the frame step and saturates the NO_DATA repeat count.
// ----------------------------------------------------------------------------
module rtpamr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wideband_mode,
	input  logic                empty,
	input  rtpamr_pkg::item_t   head,
	output logic                pop,
	rtpamr_out_if.source        frame
);
	import rtpamr_pkg::*;

	logic        v_s1;
	item_t       item_s1;
	logic        v_s2;
	item_kind_t  kind_s2;
	logic        has_byte_s2;
	logic [7:0]  data_s2;
	status_t     status_s2;
	logic        done_s2;
	logic        keep_s2;
	logic [31:0] diff_s2;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] repeat_q;
	status_t     status_q;
	logic        done_q;

	logic        adv_out;
	logic        load_s2;
	logic        load_s1;
	logic [32:0] step_lim;
	logic        gap;
	logic [31:0] diff;
	logic        sat;
	logic [18:0] quot_x;
	logic [38:0] prod;

	assign adv_out = !out_valid_q || frame.ready;
	assign load_s2 = !v_s2 || adv_out;
	assign load_s1 = !v_s1 || load_s2;
	assign pop     = load_s1 && !empty;

	assign step_lim = {1'b0, item_s1.prev_timestamp}
		+ (wideband_mode ? 33'(WB_STEP) : 33'(NB_STEP));
	assign gap      = {1'b0, item_s1.timestamp} > step_lim;
	assign diff     = item_s1.timestamp - item_s1.prev_timestamp - 32'd1;

	assign sat      = diff_s2 >= (wideband_mode ? WB_SAT_LIMIT : NB_SAT_LIMIT);
	assign quot_x   = wideband_mode ? diff_s2[24:6] : diff_s2[23:5];
	assign prod     = 39'(quot_x) * 39'(DIV5_MULT);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= head;
		end
		if (load_s2) begin
			kind_s2     <= item_s1.kind;
			has_byte_s2 <= item_s1.has_byte;
			data_s2     <= item_s1.data;
			status_s2   <= item_s1.status;
			done_s2     <= item_s1.done;
			keep_s2     <= (item_s1.kind == KIND_DATA) || gap;
			diff_s2     <= diff;
		end
		if (adv_out) begin
			if (kind_s2 == KIND_GAP) begin
				out_byte_q <= NO_DATA_BYTE;
				repeat_q   <= sat ? REPEAT_MAX : prod[DIV5_SHIFT +: 16];
				status_q   <= ST_OK;
				done_q     <= 1'b0;
			end else begin
				out_byte_q <= data_s2;
				repeat_q   <= {15'd0, has_byte_s2};
				status_q   <= status_s2;
				done_q     <= done_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= !empty;
			end
			if (load_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				out_valid_q <= v_s2 && keep_s2;
			end
		end
	end

	assign frame.valid        = out_valid_q;
	assign frame.out_byte     = out_byte_q;
	assign frame.repeat_count = repeat_q;
	assign frame.status       = status_q;
	assign frame.frame_done   = done_q;

endmodule

/* src/rtp_amr_be_depacketizer_unit.sv */
// ----------------------------------------------------------------------------
// rtp_amr_be_depacketizer_unit: RTP AMR bandwidth-efficient depacketizer
// Feed RTP packet bytes from header byte 0 on the packet channel, one
// transfer per byte, with last_byte set on the final byte of each packet.
// Results leave on the frame channel: a storage byte with a repeat count,
// or a status-only transfer (repeat_count zero) for a dropped packet.
// A timestamp gap yields one NO_DATA transfer carrying the frame count.
// One byte is taken per cycle while the queue is not full; the front end
// parses and realigns, a small queue holds classified items, and the back
// end divides the gap by the frame step through a reciprocal multiply before
// the output register. Each result passes the queue, stages s1 and s2 and
// the output register. When the receiver stalls, the back end holds, the
// queue fills and ready on the packet channel drops once the queue is full.
// Reset clears the parser state, the previous header fields, the queue and
// the narrowband/wideband setting. Write cfg_wdata with cfg_we only while
// no packet is in flight.
// ----------------------------------------------------------------------------
module rtp_amr_be_depacketizer_unit #(
	parameter int unsigned QUEUE_DEPTH = rtpamr_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	rtpamr_in_if.sink    packet,
	rtpamr_out_if.source frame
);
	import rtpamr_pkg::*;

	logic  wideband_q;
	logic  queue_full;
	logic  queue_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wideband_q <= 1'b0;
		end else if (cfg_we) begin
			wideband_q <= cfg_wdata;
		end
	end

	rtpamr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.wideband_mode (wideband_q),
		.packet        (packet),
		.queue_full    (queue_full),
		.push          (push),
		.push_item     (push_item)
	);

	rtpamr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.head      (head)
	);

	rtpamr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.wideband_mode (wideband_q),
		.empty         (queue_empty),
		.head          (head),
		.pop           (pop),
		.frame         (frame)
	);

endmodule
